FILE: design/itp_pkg.sv
// Shared types, codes and sizes for the infix to postfix converter.
// No dependencies; imported by every module of the block.
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [31:0] PREC_RESET = 32'h0000_2211;

  localparam logic [2:0] FUNC_NUMBER = 3'd0;
  localparam logic [2:0] FUNC_OPER   = 3'd1;
  localparam logic [2:0] FUNC_LPAREN = 3'd2;
  localparam logic [2:0] FUNC_RPAREN = 3'd3;
  localparam logic [2:0] FUNC_END    = 3'd4;

  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_OPER   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_OPEN    = 3'd1;
  localparam logic [2:0] ERR_NO_CLOSE   = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd3;
  localparam logic [2:0] ERR_BAD_TOKEN  = 3'd4;

  localparam logic [3:0] LPAREN_MARK = 4'd8;

  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         op_code;
    logic signed [31:0] number_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [2:0]         out_op;
    logic signed [31:0] out_value;
    logic [2:0]         error_code;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic       load_in;
    logic       emit;
    logic [1:0] emit_kind;
    logic [2:0] err_code;
    logic       last;
    logic       pop;
    logic       push;
    logic       clear;
  } itp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       empty;
    logic       full;
    logic       one_left;
    logic       top_lp;
    logic       top_ge;
    logic       next_lp;
    logic       next_ge;
    logic       has_lp;
    logic       slot_free;
  } itp_status_t;

endpackage

FILE: design/itp_datapath.sv
// Datapath: token register, precedence register, operator stack and result register.
// Depends on itp_pkg; driven by itp_controller through itp_cmd_t.
module itp_datapath import itp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  in_item_t    in_data,
  input  logic        out_ready,
  input  itp_cmd_t    cmd,
  output itp_status_t status,
  output logic        out_valid,
  output out_item_t   out_data
);

  logic [31:0]      prec_table;
  in_item_t         tok;
  logic [3:0]       stack_mem [STACK_DEPTH];
  logic [3:0]       top;
  logic [3:0]       rd_data;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lp_count;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] count_m2;
  logic [CNT_W-1:0] count_m3;
  logic [3:0]       p_tok;
  logic [3:0]       p_top;
  logic [3:0]       p_next;
  logic [3:0]       push_val;

  assign count_m1 = count - CNT_W'(1);
  assign count_m2 = count - CNT_W'(2);
  assign count_m3 = count - CNT_W'(3);
  assign p_tok    = prec_table[{tok.op_code, 2'b00} +: 4];
  assign p_top    = prec_table[{top[2:0], 2'b00} +: 4];
  assign p_next   = prec_table[{rd_data[2:0], 2'b00} +: 4];
  assign push_val = (tok.func == FUNC_LPAREN) ? LPAREN_MARK : {1'b0, tok.op_code};

  always_comb begin
    status.func      = tok.func;
    status.empty     = (count == '0);
    status.full      = (count == CNT_W'(STACK_DEPTH));
    status.one_left  = (count == CNT_W'(1));
    status.top_lp    = (top == LPAREN_MARK);
    status.top_ge    = (p_top >= p_tok);
    status.next_lp   = (rd_data == LPAREN_MARK);
    status.next_ge   = (p_next >= p_tok);
    status.has_lp    = (lp_count != '0);
    status.slot_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prec_table <= PREC_RESET;
    end else if (cfg_valid) begin
      prec_table <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tok <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rd_data <= top;
    end else if (cmd.pop) begin
      rd_data <= stack_mem[count_m3[IDX_W-1:0]];
    end else begin
      rd_data <= stack_mem[count_m2[IDX_W-1:0]];
    end
    if (cmd.push && count != '0) begin
      stack_mem[count_m1[IDX_W-1:0]] <= top;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= push_val;
    end else if (cmd.pop) begin
      top <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count    <= '0;
      lp_count <= '0;
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
      if (push_val == LPAREN_MARK) begin
        lp_count <= lp_count + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      count <= count_m1;
      if (top == LPAREN_MARK) begin
        lp_count <= lp_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_kind   <= cmd.emit_kind;
      out_data.out_op     <= (cmd.emit_kind == KIND_OPER) ? top[2:0] : 3'd0;
      out_data.out_value  <= (cmd.emit_kind == KIND_NUMBER) ? tok.number_value : 32'sd0;
      out_data.error_code <= (cmd.emit_kind == KIND_ERROR) ? cmd.err_code : ERR_NONE;
      out_data.last       <= cmd.last;
    end
  end

endmodule

FILE: design/itp_controller.sv
// Controller state machine: sequences accept, pops, push, number results and error reports per token.
// Depends on itp_pkg; talks to itp_datapath through itp_cmd_t and itp_status_t.
module itp_controller import itp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  itp_status_t status,
  output itp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_NUM    = 3'd3;
  localparam logic [2:0] S_ERR    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] err_code;
  logic [2:0] err_code_next;
  logic       pop_last;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (status.func)
      FUNC_OPER:   pop_last = status.one_left || status.next_lp || !status.next_ge;
      FUNC_RPAREN: pop_last = status.next_lp;
      default:     pop_last = status.one_left;
    endcase
  end

  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (status.func)
          FUNC_NUMBER: begin
            state_next = S_NUM;
          end
          FUNC_OPER: begin
            if (!status.empty && !status.top_lp && status.top_ge) begin
              state_next = S_POP;
            end else if (status.full) begin
              err_code_next = ERR_OVERFLOW;
              state_next    = S_ERR;
            end else begin
              cmd.push   = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_LPAREN: begin
            if (status.full) begin
              err_code_next = ERR_OVERFLOW;
              state_next    = S_ERR;
            end else begin
              cmd.push   = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_RPAREN: begin
            if (!status.has_lp) begin
              err_code_next = ERR_NO_OPEN;
              state_next    = S_ERR;
            end else if (status.top_lp) begin
              cmd.pop    = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_POP;
            end
          end
          FUNC_END: begin
            if (status.has_lp) begin
              err_code_next = ERR_NO_CLOSE;
              state_next    = S_ERR;
            end else if (status.empty) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_POP;
            end
          end
          default: begin
            err_code_next = ERR_BAD_TOKEN;
            state_next    = S_ERR;
          end
        endcase
      end
      S_POP: begin
        if (status.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_OPER;
          cmd.last      = pop_last;
          cmd.pop       = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_NUM: begin
        if (status.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_NUMBER;
          cmd.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ERR: begin
        if (status.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_ERROR;
          cmd.err_code  = err_code;
          cmd.last      = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_code <= ERR_NONE;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

endmodule

FILE: design/infix_to_postfix_converter_core.sv
// Infix to postfix converter: top level joining controller and datapath.
// Depends on itp_pkg, itp_controller and itp_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one infix token per
//   transaction. Output channel (out_valid/out_ready/out_data) returns the
//   postfix results; last marks the final result of a token. Tokens that
//   cause no result (push, empty paren pair, end on empty stack) return none.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the precedence
//   table; cfg_ready is always high and writes belong between expressions.
// Sequence:
//   A token is accepted in the idle state and then decided; each operator
//   popped off the stack goes through an emit state, then a re-decide,
//   since the stack memory read under the top is registered. A number or an
//   error report is emitted from its own state after the decision.
//   The result register holds one result; while the receiver stalls the
//   block holds in its emit state and accepts no token.
// Reset:
//   rst clears the stack count, the output valid and restores the
//   precedence table to 0x2211.
module infix_to_postfix_converter_core import itp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  itp_cmd_t    cmd;
  itp_status_t status;

  assign cfg_ready = 1'b1;

  itp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  itp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
